>>> hw/rtl/osc_int_pkg.sv
// ----------------------------------------------------------------------------
// Oscillator integration step package
// Shared constants and arithmetic helpers for the integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_int_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 28;
  localparam int CordicIters = 30;
  localparam int CountWidth = 21;

  typedef logic signed [DataWidth-1:0] data_t;

  localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};

  // round(2^28 / 6) and 0.5
  localparam logic signed [DataWidth-1:0] Sixth = 32'sd44739243;
  localparam logic signed [DataWidth-1:0] Half  = 32'sd134217728;

  // pi, 2*pi and pi/2 in Q4.28
  localparam logic [DataWidth-1:0] PiF    = 32'd843314857;
  localparam logic [DataWidth-1:0] TwoPiF = 32'd1686629713;
  localparam logic [DataWidth-1:0] HalfPi = 32'd421657428;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    METH_RK4 = 2'd0,
    METH_RK2 = 2'd1,
    METH_EC  = 2'd2,
    METH_NOP = 2'd3
  } method_t;

  typedef enum logic [2:0] {
    CFG_METHOD = 3'd0,
    CFG_DT     = 3'd1,
    CFG_W      = 3'd2,
    CFG_X0     = 3'd3,
    CFG_STEPS  = 3'd4
  } cfg_idx_t;

  function automatic logic [31:0] cordic_atan(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd843314856;
        5'd1: r = 32'd497837829;
        5'd2: r = 32'd263043836;
        5'd3: r = 32'd133525158;
        5'd4: r = 32'd67021686;
        5'd5: r = 32'd33543515;
        5'd6: r = 32'd16775850;
        5'd7: r = 32'd8388437;
        5'd8: r = 32'd4194282;
        5'd9: r = 32'd2097149;
        default: r = (32'd1 << (5'd30 - i)) - 32'd1;
      endcase
      cordic_atan = r;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/oscillator_integration_step_top.sv
// ----------------------------------------------------------------------------
// Oscillator integration step
// Advances position and velocity by one time step per item.
// ----------------------------------------------------------------------------
// Each accepted item advances a Q4.28 oscillator state by one step using RK4,
// midpoint RK2 or Euler-Cromer with a CORDIC sine force. All arithmetic but
// that of the sine unit goes through one shared saturating ALU (one 32x32
// multiply or one add/subtract per cycle) driven by a microcode sequencer.
// Euler-Cromer updates the position on the ALU, reduces it modulo 2pi by
// restoring subtraction, loads the CORDIC, runs 30 CORDIC rotations and a
// sine fix-up, then finishes the velocity on the ALU; an unused method code
// does no arithmetic. Every item ends by loading the output register and
// returning to idle; the result becomes valid in the same cycle that the
// input is ready again. The input is not ready while an item is in work. A
// finished result waits in the output register while the next item is
// already taken and worked on; only the load of the next result stalls until
// the waiting one has left. A restart item reloads the start position, clears
// velocity and the step count, then steps.
// ----------------------------------------------------------------------------
`default_nettype none

module oscillator_integration_step_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [31:0] position_out, [63:32] velocity_out
  output logic             out_tlast,  // run_last
  output logic             out_tuser,  // saturated
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  typedef logic signed [31:0] d_t;

  // ALU operations
  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB} op_t;
  // operand sources
  typedef enum logic [3:0] {
    S_X, S_V, S_W, S_DT, S_HALF, S_SIXTH, S_T0, S_T1, S_T2, S_T3, S_K1, S_K2,
    S_ZERO, S_XO, S_SIN
  } src_t;
  // destinations
  typedef enum logic [3:0] {
    D_T0, D_T1, D_T2, D_T3, D_K1, D_K2, D_XN, D_VN, D_SIN, D_NONE
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t d;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_MOD, ST_CORDIC, ST_SINFIX, ST_OUT
  } state_t;

  // configuration
  logic [1:0]  meth_r;
  logic [28:0] dt_r;
  logic [30:0] w_r;
  d_t          x0_r;
  logic [20:0] spr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meth_r <= 2'd0;
      dt_r   <= 29'd2684355;
      w_r    <= 31'd268435456;
      x0_r   <= 32'sd26843546;
      spr_r  <= 21'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        osc_int_pkg::CFG_METHOD: meth_r <= cfg_wdata[1:0];
        osc_int_pkg::CFG_DT:     dt_r   <= cfg_wdata[28:0];
        osc_int_pkg::CFG_W:      w_r    <= cfg_wdata[30:0];
        osc_int_pkg::CFG_X0:     x0_r   <= cfg_wdata;
        osc_int_pkg::CFG_STEPS:  spr_r  <= cfg_wdata[20:0];
        default: ;
      endcase
    end
  end

  // Microcode. Per-method programs; k1x/k2x etc. are held in temporaries.
  // RK4 register use: T0 = k-sum for x, T1 = k-sum for v, K1 = kx, K2 = kv,
  // XN and its copy T3 midpoint position, T2 scratch.
  localparam int Rk4Len = 36;
  localparam int Rk2Len = 15;

  function automatic uop_t mk(op_t o, src_t a, src_t b, dst_t d);
    uop_t u;
    begin
      u.op = o; u.a = a; u.b = b; u.d = d;
      mk = u;
    end
  endfunction

  function automatic uop_t rk4_rom(input logic [5:0] pc);
    uop_t u;
    begin
      case (pc)
        // k1x = v, k1v = -(w*x)
        6'd0:  u = mk(OP_MUL, S_W, S_X, D_T2);
        6'd1:  u = mk(OP_SUB, S_ZERO, S_T2, D_K2);
        6'd2:  u = mk(OP_ADD, S_V, S_ZERO, D_K1);
        6'd3:  u = mk(OP_ADD, S_K1, S_ZERO, D_T0);       // sum_x = k1x
        6'd4:  u = mk(OP_ADD, S_K2, S_ZERO, D_T1);       // sum_v = k1v
        // midpoint 1
        6'd5:  u = mk(OP_MUL, S_K1, S_DT, D_T2);
        6'd6:  u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd7:  u = mk(OP_ADD, S_X, S_T2, D_XN);
        6'd8:  u = mk(OP_MUL, S_K2, S_DT, D_T2);
        6'd9:  u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd10: u = mk(OP_ADD, S_V, S_T2, D_K1);          // k2x = vn
        6'd11: u = mk(OP_MUL, S_W, S_T3, D_T2);          // T3 holds xn
        6'd12: u = mk(OP_SUB, S_ZERO, S_T2, D_K2);       // k2v
        6'd13: u = mk(OP_ADD, S_K1, S_K1, D_T2);
        6'd14: u = mk(OP_ADD, S_T0, S_T2, D_T0);
        6'd15: u = mk(OP_ADD, S_K2, S_K2, D_T2);
        6'd16: u = mk(OP_ADD, S_T1, S_T2, D_T1);
        // midpoint 2
        6'd17: u = mk(OP_MUL, S_K1, S_DT, D_T2);
        6'd18: u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd19: u = mk(OP_ADD, S_X, S_T2, D_XN);
        6'd20: u = mk(OP_MUL, S_K2, S_DT, D_T2);
        6'd21: u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd22: u = mk(OP_ADD, S_V, S_T2, D_K1);          // k3x
        6'd23: u = mk(OP_MUL, S_W, S_T3, D_T2);
        6'd24: u = mk(OP_SUB, S_ZERO, S_T2, D_K2);       // k3v
        6'd25: u = mk(OP_ADD, S_K1, S_K1, D_T2);
        6'd26: u = mk(OP_ADD, S_T0, S_T2, D_T0);
        6'd27: u = mk(OP_ADD, S_K2, S_K2, D_T2);
        6'd28: u = mk(OP_ADD, S_T1, S_T2, D_T1);
        // full step
        6'd29: u = mk(OP_MUL, S_K1, S_DT, D_T2);
        6'd30: u = mk(OP_ADD, S_X, S_T2, D_XN);
        6'd31: u = mk(OP_MUL, S_K2, S_DT, D_T2);
        6'd32: u = mk(OP_ADD, S_V, S_T2, D_K1);          // k4x
        6'd33: u = mk(OP_MUL, S_W, S_T3, D_T2);
        6'd34: u = mk(OP_SUB, S_ZERO, S_T2, D_K2);       // k4v
        default: u = mk(OP_ADD, S_T0, S_K1, D_T0);
      endcase
      rk4_rom = u;
    end
  endfunction

  // RK4 tail: adds k4v to sum_v, then x += (sixth*sum_x)*dt, v likewise
  function automatic uop_t tail_rom(input logic [2:0] pc);
    uop_t u;
    begin
      case (pc)
        3'd0: u = mk(OP_ADD, S_T1, S_K2, D_T1);
        3'd1: u = mk(OP_MUL, S_SIXTH, S_T0, D_T2);
        3'd2: u = mk(OP_MUL, S_T2, S_DT, D_T2);
        3'd3: u = mk(OP_ADD, S_X, S_T2, D_XN);
        3'd4: u = mk(OP_MUL, S_SIXTH, S_T1, D_T2);
        3'd5: u = mk(OP_MUL, S_T2, S_DT, D_T2);
        default: u = mk(OP_ADD, S_V, S_T2, D_VN);
      endcase
      tail_rom = u;
    end
  endfunction

  function automatic uop_t rk2_rom(input logic [5:0] pc);
    uop_t u;
    begin
      case (pc)
        6'd0:  u = mk(OP_MUL, S_W, S_X, D_T2);
        6'd1:  u = mk(OP_SUB, S_ZERO, S_T2, D_K2);
        6'd2:  u = mk(OP_ADD, S_V, S_ZERO, D_K1);
        6'd3:  u = mk(OP_MUL, S_K1, S_DT, D_T2);
        6'd4:  u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd5:  u = mk(OP_ADD, S_X, S_T2, D_XN);
        6'd6:  u = mk(OP_MUL, S_K2, S_DT, D_T2);
        6'd7:  u = mk(OP_MUL, S_T2, S_HALF, D_T2);
        6'd8:  u = mk(OP_ADD, S_V, S_T2, D_K1);
        6'd9:  u = mk(OP_MUL, S_W, S_T3, D_T2);
        6'd10: u = mk(OP_SUB, S_ZERO, S_T2, D_K2);
        6'd11: u = mk(OP_MUL, S_K1, S_DT, D_T2);
        6'd12: u = mk(OP_ADD, S_X, S_T2, D_T0);
        6'd13: u = mk(OP_MUL, S_K2, S_DT, D_T2);
        // the new velocity goes straight to the state register
        default: u = mk(OP_ADD, S_V, S_T2, D_NONE);
      endcase
      rk2_rom = u;
    end
  endfunction

  // Euler-Cromer: x first, then sine evaluation, then v
  function automatic uop_t ec_rom(input logic [5:0] pc);
    uop_t u;
    begin
      case (pc)
        6'd0: u = mk(OP_MUL, S_V, S_DT, D_T2);
        6'd1: u = mk(OP_ADD, S_X, S_T2, D_XN);   // triggers sine
        6'd2: u = mk(OP_MUL, S_W, S_SIN, D_T2);
        6'd3: u = mk(OP_MUL, S_T2, S_DT, D_T2);
        default: u = mk(OP_SUB, S_V, S_T2, D_VN);
      endcase
      ec_rom = u;
    end
  endfunction

  // state
  state_t      st_r;
  logic [5:0]  pc_r;
  logic        tail_r;
  d_t          x_r, v_r, xn_r;
  d_t          t0_r, t1_r, t2_r, t3_r, k1_r, k2_r, sin_r;
  logic [20:0] cnt_r;
  logic        sat_r;
  d_t          xo_r, vo_r;
  logic        last_r, osat_r, ovalid_r;

  // sine unit registers
  logic [31:0] m_r;       // magnitude being reduced
  logic [31:0] dsr_r;     // 2pi for restoring remainder
  logic [5:0]  mcnt_r;
  logic        sneg_r;
  logic signed [33:0] cx_r, cy_r, z_r;
  logic [4:0]  ci_r;

  // micro-op select
  uop_t uop;
  always_comb begin
    if (tail_r) uop = tail_rom(pc_r[2:0]);
    else begin
      unique case (meth_r)
        osc_int_pkg::METH_RK4: uop = rk4_rom(pc_r);
        osc_int_pkg::METH_RK2: uop = rk2_rom(pc_r);
        default:               uop = ec_rom(pc_r);
      endcase
    end
  end

  function automatic d_t pick(src_t s, d_t x, d_t v, d_t w, d_t dt, d_t a0, d_t a1,
                              d_t a2, d_t a3, d_t k1, d_t k2, d_t xo, d_t sn);
    d_t r;
    begin
      case (s)
        S_X: r = x; S_V: r = v; S_W: r = w; S_DT: r = dt;
        S_HALF: r = osc_int_pkg::Half; S_SIXTH: r = osc_int_pkg::Sixth;
        S_T0: r = a0; S_T1: r = a1; S_T2: r = a2; S_T3: r = a3;
        S_K1: r = k1; S_K2: r = k2; S_XO: r = xo; S_SIN: r = sn;
        default: r = '0;
      endcase
      pick = r;
    end
  endfunction

  d_t opa, opb;
  assign opa = pick(uop.a, x_r, v_r, {1'b0, w_r}, {3'b0, dt_r}, t0_r, t1_r, t2_r,
                    t3_r, k1_r, k2_r, xo_r, sin_r);
  assign opb = pick(uop.b, x_r, v_r, {1'b0, w_r}, {3'b0, dt_r}, t0_r, t1_r, t2_r,
                    t3_r, k1_r, k2_r, xo_r, sin_r);

  // shared saturating ALU
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [35:0] qhi;
  logic        pneg;
  logic signed [32:0] sum33;
  d_t          res;
  logic        res_sat;
  always_comb begin
    ma    = opa[31] ? 32'(-opa) : opa;
    mb    = opb[31] ? 32'(-opb) : opb;
    prod  = ma * mb;
    pneg  = opa[31] ^ opb[31];
    qhi   = prod[63:28];
    res   = '0;
    res_sat = 1'b0;
    sum33 = '0;
    unique case (uop.op)
      OP_MUL: begin
        if (pneg) begin
          if (qhi > 36'h080000000) begin
            res = osc_int_pkg::VMin; res_sat = 1'b1;
          end else res = 32'(-qhi);
        end else begin
          if (qhi > 36'h07fffffff) begin
            res = osc_int_pkg::VMax; res_sat = 1'b1;
          end else res = qhi[31:0];
        end
      end
      default: begin
        if (uop.op == OP_ADD) sum33 = 33'(opa) + 33'(opb);
        else sum33 = 33'(opa) - 33'(opb);
        if (sum33 > 33'sh07fffffff) begin
          res = osc_int_pkg::VMax; res_sat = 1'b1;
        end else if (sum33 < -33'sh080000000) begin
          res = osc_int_pkg::VMin; res_sat = 1'b1;
        end else res = sum33[31:0];
      end
    endcase
  end

  // end of program markers
  logic prog_end;
  always_comb begin
    if (tail_r) prog_end = (pc_r == 6'd6);
    else begin
      unique case (meth_r)
        osc_int_pkg::METH_RK4: prog_end = (pc_r == 6'(Rk4Len - 1));
        osc_int_pkg::METH_RK2: prog_end = (pc_r == 6'(Rk2Len - 1));
        default:               prog_end = (pc_r == 6'd4);
      endcase
    end
  end

  // CORDIC step
  logic signed [33:0] dx, dy, ang;
  assign dx  = cy_r >>> ci_r;
  assign dy  = cx_r >>> ci_r;
  assign ang = 34'(osc_int_pkg::cordic_atan(ci_r));

  // sine fold after reduction
  logic [31:0] mf1, mf2;
  logic        nf;
  always_comb begin
    mf1 = m_r;
    nf  = sneg_r;
    if (mf1 >= osc_int_pkg::PiF) begin
      mf1 = mf1 - osc_int_pkg::PiF;
      nf = ~nf;
    end
    mf2 = (mf1 > osc_int_pkg::HalfPi) ? osc_int_pkg::PiF - mf1 : mf1;
  end

  logic [32:0] msub;
  assign msub = {1'b0, m_r} - {1'b0, dsr_r};

  logic fire;
  assign fire = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      pc_r     <= '0;
      tail_r   <= 1'b0;
      x_r      <= 32'sd26843546;
      v_r      <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      sat_r    <= 1'b0;
    end else begin
      // The output register loads only when it is empty or being emptied.
      if (st_r == ST_OUT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (fire) begin
            sat_r  <= 1'b0;
            pc_r   <= '0;
            tail_r <= 1'b0;
            if (in_tdata[0]) begin
              x_r   <= x0_r;
              v_r   <= '0;
              cnt_r <= '0;
            end
            st_r <= (meth_r == osc_int_pkg::METH_NOP) ? ST_OUT : ST_RUN;
          end
        end
        ST_RUN: begin
          sat_r <= sat_r | res_sat;
          unique case (uop.d)
            D_T0: t0_r <= res; D_T1: t1_r <= res; D_T2: t2_r <= res;
            D_T3: t3_r <= res; D_K1: k1_r <= res; D_K2: k2_r <= res;
            D_XN: begin t3_r <= res; xn_r <= res; end
            D_VN: v_r <= res;
            default: ;
          endcase
          if (meth_r == osc_int_pkg::METH_RK2 && pc_r == 6'(Rk2Len - 1)) begin
            // final RK2 update: x was formed earlier in T0, v now
            x_r <= t0_r;
            v_r <= res;
            st_r <= ST_OUT;
          end else if (meth_r == osc_int_pkg::METH_EC && pc_r == 6'd1) begin
            x_r    <= res;
            sneg_r <= res[31];
            m_r    <= res[31] ? 32'(-res) : res;
            dsr_r  <= osc_int_pkg::TwoPiF;
            mcnt_r <= '0;
            st_r   <= ST_MOD;
          end else if (prog_end) begin
            if (meth_r == osc_int_pkg::METH_RK4 && !tail_r) begin
              tail_r <= 1'b1;
              pc_r   <= '0;
            end else begin
              if (tail_r) x_r <= xn_r;
              st_r <= ST_OUT;
            end
          end else begin
            pc_r <= pc_r + 6'd1;
          end
        end
        ST_MOD: begin
          // The magnitude is at most 2^31, below twice 2*pi, so at most the first
          // restoring subtract takes 2*pi off and the second leaves it as is.
          if (!msub[32]) m_r <= msub[31:0];
          mcnt_r <= mcnt_r + 6'd1;
          if (mcnt_r == 6'd1) begin
            st_r <= ST_CORDIC;
            ci_r <= '0;
          end
        end
        ST_CORDIC: begin
          if (ci_r == 5'd0 && mcnt_r == 6'd2) begin
            sneg_r <= nf;
            cx_r   <= osc_int_pkg::CordicGain;
            cy_r   <= '0;
            z_r    <= {mf2, 2'b00};
            mcnt_r <= 6'd3;
          end else begin
            if (!z_r[33]) begin
              cx_r <= cx_r - dx; cy_r <= cy_r + dy; z_r <= z_r - ang;
            end else begin
              cx_r <= cx_r + dx; cy_r <= cy_r - dy; z_r <= z_r + ang;
            end
            ci_r <= ci_r + 5'd1;
            if (ci_r == 5'(osc_int_pkg::CordicIters - 1)) st_r <= ST_SINFIX;
          end
        end
        ST_SINFIX: begin
          if (sneg_r) sin_r <= 32'(-(cy_r >>> 2));
          else sin_r <= 32'(cy_r >>> 2);
          pc_r <= 6'd2;
          st_r <= ST_RUN;
        end
        default: begin
          // ST_OUT: wait until the previous result has left the output register.
          if (!ovalid_r || out_tready) begin
            xo_r     <= x_r;
            vo_r     <= v_r;
            osat_r   <= sat_r;
            last_r   <= ((cnt_r + 21'd1) == spr_r);
            cnt_r    <= ((cnt_r + 21'd1) == spr_r) ? 21'd0 : cnt_r + 21'd1;
            st_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {vo_r, xo_r};
  assign out_tlast  = last_r;
  assign out_tuser  = osat_r;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator integration step testbench
// Drives step items through the stream input, predicts each new state with an
// independent fixed-point integrator, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic        last;
    logic        sat;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_wdata = 32'd0;

  // Idle percentages for the sender and the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;

  // Predicted oscillator: configuration and state.
  logic [1:0]  p_method = osc_int_pkg::METH_RK4;
  longint      p_dt = 2684355;
  longint      p_w = 268435456;
  longint      p_x0 = 26843546;
  logic [20:0] p_run_len = 21'd3000;
  longint      p_pos = 26843546;
  longint      p_vel = 0;
  logic [20:0] p_count = 21'd0;
  bit          p_sat;

  step_result_t pending_steps[$];

  longint atan_q30[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149};

  oscillator_integration_step_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Saturating arithmetic on the 32-bit signed range; every clamp marks the step.
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      p_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      p_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return sat32(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return sat32(a - b);
  endfunction

  // Magnitude product truncated toward zero, then clamped.
  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, q, lim;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = (ma * mb) >> osc_int_pkg::FracBits;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) begin
      p_sat = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fx_half(longint k);
    return fx_mul(fx_mul(k, p_dt), longint'(osc_int_pkg::Half));
  endfunction

  function automatic longint fx_weigh(longint k1, longint k2, longint k3, longint k4);
    return fx_add(fx_add(fx_add(k1, fx_add(k2, k2)), fx_add(k3, k3)), k4);
  endfunction

  // Sine by reduction modulo two pi, folding into the first quadrant, then CORDIC.
  function automatic longint fx_sine(longint xv);
    bit neg;
    longint unsigned m;
    longint cx, cy, z, s, dx, dy, ang;
    neg = xv < 0;
    m = (xv < 0) ? -xv : xv;
    m = m % longint'(osc_int_pkg::TwoPiF);
    if (m >= longint'(osc_int_pkg::PiF)) begin
      m = m - longint'(osc_int_pkg::PiF);
      neg = !neg;
    end
    if (m > longint'(osc_int_pkg::HalfPi)) m = longint'(osc_int_pkg::PiF) - m;
    z = longint'(m << 2);
    cx = longint'(osc_int_pkg::CordicGain);
    cy = 0;
    for (int i = 0; i < osc_int_pkg::CordicIters; i++) begin
      ang = (i < 10) ? atan_q30[i] : (64'sd1 <<< (30 - i)) - 1;
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx; cy = cy + dy; z = z - ang;
      end else begin
        cx = cx + dx; cy = cy - dy; z = z + ang;
      end
    end
    s = sat32(cy >>> 2);
    return neg ? fx_sub(0, s) : s;
  endfunction

  // Advances the predicted oscillator by one step and returns the expected result.
  function automatic step_result_t integrate_step(bit restart);
    step_result_t r;
    longint x, v, k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v, xn, vn, sixth;
    logic [20:0] nxt;
    sixth = longint'(osc_int_pkg::Sixth);
    if (restart) begin
      p_pos = p_x0;
      p_vel = 0;
      p_count = 21'd0;
    end
    p_sat = 1'b0;
    x = p_pos;
    v = p_vel;
    case (p_method)
      osc_int_pkg::METH_RK4, osc_int_pkg::METH_RK2: begin
        k1x = v;
        k1v = fx_sub(0, fx_mul(p_w, x));
        xn = fx_add(x, fx_half(k1x));
        vn = fx_add(v, fx_half(k1v));
        k2x = vn;
        k2v = fx_sub(0, fx_mul(p_w, xn));
        if (p_method == osc_int_pkg::METH_RK2) begin
          x = fx_add(x, fx_mul(k2x, p_dt));
          v = fx_add(v, fx_mul(k2v, p_dt));
        end else begin
          xn = fx_add(x, fx_half(k2x));
          vn = fx_add(v, fx_half(k2v));
          k3x = vn;
          k3v = fx_sub(0, fx_mul(p_w, xn));
          xn = fx_add(x, fx_mul(k3x, p_dt));
          vn = fx_add(v, fx_mul(k3v, p_dt));
          k4x = vn;
          k4v = fx_sub(0, fx_mul(p_w, xn));
          x = fx_add(x, fx_mul(fx_mul(sixth, fx_weigh(k1x, k2x, k3x, k4x)), p_dt));
          v = fx_add(v, fx_mul(fx_mul(sixth, fx_weigh(k1v, k2v, k3v, k4v)), p_dt));
        end
      end
      osc_int_pkg::METH_EC: begin
        x = fx_add(x, fx_mul(v, p_dt));
        v = fx_sub(v, fx_mul(fx_mul(p_w, fx_sine(x)), p_dt));
      end
      default: ;  // unused method holds the state but still counts the step
    endcase
    p_pos = x;
    p_vel = v;
    nxt = p_count + 21'd1;
    r.last = (nxt == p_run_len);
    if (r.last) nxt = 21'd0;
    p_count = nxt;
    r.pos = x[31:0];
    r.vel = v[31:0];
    r.sat = p_sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Receiver: random back-pressure, and the check of each accepted result
  // against the oldest predicted step.
  always @(posedge clk) begin
    step_result_t e;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steps.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'd0);
      end else begin
        e = pending_steps.pop_front();
        if (out_tdata[31:0] !== e.pos) report_mismatch("position", out_tdata[31:0], e.pos);
        if (out_tdata[63:32] !== e.vel) report_mismatch("velocity", out_tdata[63:32], e.vel);
        if (out_tlast !== e.last) report_mismatch("run_last", out_tlast, e.last);
        if (out_tuser !== e.sat) report_mismatch("saturated", out_tuser, e.sat);
      end
    end
  end

  // Sends one step item, with random idle cycles ahead of it. The valid is only
  // lowered during idle cycles, so back-to-back items keep it high.
  task automatic send_step(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    pending_steps.push_back(integrate_step(restart));
  endtask

  // Lets every outstanding result arrive, plus a margin.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write while idle; the predicted copy follows the register width.
  task automatic write_reg(osc_int_pkg::cfg_idx_t idx, logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      osc_int_pkg::CFG_METHOD: p_method = value[1:0];
      osc_int_pkg::CFG_DT:     p_dt = longint'(value[28:0]);
      osc_int_pkg::CFG_W:      p_w = longint'(value[30:0]);
      osc_int_pkg::CFG_X0:     p_x0 = longint'(signed'(value));
      osc_int_pkg::CFG_STEPS:  p_run_len = value[20:0];
      default: ;
    endcase
  endtask

  task automatic run_steps(int n);
    for (int i = 0; i < n; i++) send_step(i == 0);
  endtask

  // Each method at reset settings but a run length of 3, then the unused method code.
  task automatic test_methods;
    write_reg(osc_int_pkg::CFG_STEPS, 32'd3);
    for (int m = 0; m < 4; m++) begin
      write_reg(osc_int_pkg::CFG_METHOD, m);
      run_steps(4);
    end
  endtask

  // Extremes of dt, stiffness and start position, where clamping takes over.
  task automatic test_extremes;
    write_reg(osc_int_pkg::CFG_METHOD, osc_int_pkg::METH_RK4);
    write_reg(osc_int_pkg::CFG_DT, 32'd268435456);
    write_reg(osc_int_pkg::CFG_W, 32'h7fffffff);
    write_reg(osc_int_pkg::CFG_X0, 32'h7fffffff);
    run_steps(3);
    write_reg(osc_int_pkg::CFG_METHOD, osc_int_pkg::METH_EC);
    write_reg(osc_int_pkg::CFG_X0, 32'h80000000);
    run_steps(3);
    write_reg(osc_int_pkg::CFG_DT, 32'd1);
    write_reg(osc_int_pkg::CFG_W, 32'd0);
    write_reg(osc_int_pkg::CFG_METHOD, osc_int_pkg::METH_RK2);
    run_steps(2);
  endtask

  // Run length of one and of zero, and a counter left past the run length.
  task automatic test_run_end;
    write_reg(osc_int_pkg::CFG_STEPS, 32'd1);
    run_steps(2);
    write_reg(osc_int_pkg::CFG_STEPS, 32'd0);
    run_steps(2);
    write_reg(osc_int_pkg::CFG_STEPS, 32'd5);
    send_step(1'b0);
    send_step(1'b0);
    write_reg(osc_int_pkg::CFG_STEPS, 32'd1);
    send_step(1'b0);
  endtask

  task automatic random_settings;
    write_reg(osc_int_pkg::CFG_METHOD,
              $urandom_range(3) == 0 ? $urandom_range(3) : $urandom_range(2));
    write_reg(osc_int_pkg::CFG_DT, $urandom_range(3) == 0 ? $urandom_range(268435456, 1)
                                                           : $urandom_range(30000000, 1));
    write_reg(osc_int_pkg::CFG_W, $urandom_range(3) == 0 ? $urandom & 32'h7fffffff
                                                          : $urandom_range(1073741824));
    write_reg(osc_int_pkg::CFG_X0, $urandom_range(3) == 0 ? $urandom
                                   : $urandom_range(600000000) - 300000000);
    write_reg(osc_int_pkg::CFG_STEPS,
              $urandom_range(9) == 0 ? $urandom : $urandom_range(12, 1));
  endtask

  // Random items under the given idle pattern: mostly plain steps, some restarts.
  task automatic test_random(int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int blk = 0; blk < 5; blk++) begin
      random_settings();
      for (int i = 0; i < 30; i++) send_step($urandom_range(7) == 0);
      // Hold off after the third block until every predicted result has come back.
      if (blk == 2) drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_methods();
    test_extremes();
    test_run_end();
    test_random(24, 78);
    test_random(78, 24);
    test_random(0, 0);
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
